@@ rtl/rwga_pkg.sv @@
`default_nettype none

package rwga_pkg;

  // Grid size and derived index widths
  localparam int MAX_POINTS = 4096;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int NP_W       = 13;
  localparam int N_W        = $clog2(MAX_POINTS + 1);
  localparam int CMP_W      = (N_W > NP_W) ? N_W : NP_W;

  // Radius in grid units (Q.8) and weight (Q.16) widths
  localparam int OFS_W = 24;
  localparam int X_W   = ((OFS_W > IDX_W + 8) ? OFS_W : IDX_W + 8) + 1;
  localparam int WGT_W = 2 * X_W;
  localparam int LO_W  = 32;
  localparam int WHI_W = WGT_W - LO_W;

  // Samples, accumulators, shared multiplier
  localparam int SMP_W  = 32;
  localparam int ACC_W  = 64;
  localparam int MUL_W  = 33;
  localparam int TERM_W = WHI_W + LO_W + ACC_W + 1;

  // Divider
  localparam int DIV_STEPS = ACC_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  // Configuration port
  localparam int CIDX_W = 3;
  localparam int CFG_W  = 24;

  localparam logic [1:0] GEO_PLANAR = 2'd0;
  localparam logic [1:0] GEO_CYL    = 2'd1;
  localparam logic [1:0] GEO_SPH    = 2'd2;

  localparam logic [WGT_W-1:0] W_FULL    = WGT_W'(65536);
  localparam logic [WGT_W-1:0] W_HALF    = WGT_W'(32768);
  localparam logic [WGT_W-1:0] W_CYL_CTR = WGT_W'(8192);
  localparam logic [WGT_W-1:0] W_SPH_CTR = WGT_W'(2731);

  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [SMP_W-1:0] SMP_MAX = {1'b0, {(SMP_W-1){1'b1}}};
  localparam logic [SMP_W-1:0] SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};

  typedef enum logic [CIDX_W-1:0] {
    REG_GEOMETRY = 3'd0,
    REG_SHELL    = 3'd1,
    REG_OFFSET   = 3'd2,
    REG_POINTS   = 3'd3,
    REG_PRODUCT  = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROD,
    ST_SQR,
    ST_MLO,
    ST_MHI,
    ST_TERM,
    ST_ACC,
    ST_DINIT,
    ST_DIV,
    ST_RND,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]       geometry_mode;
    logic             is_shell;
    logic [OFS_W-1:0] grid_offset;
    logic [NP_W-1:0]  num_points;
    logic             use_product;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic prod;
    logic sqr;
    logic mlo;
    logic mhi;
    logic term;
    logic acc;
    logic dinit;
    logic dstep;
    logic rnd;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/radial_weighted_grid_average.sv @@
// Radial weighted grid average.
// s_* channel: one word per grid point, sample_f then sample_g (signed Q16.16).
// m_* channel: one word per run, the trapezoid-rule average (signed Q16.16)
//   and a flag for any saturation seen in the run.
// cfg_*: write geometry_mode, is_shell, grid_offset, num_points, use_product
//   by index while no run is in flight; writes take effect at once.
// Timing: an accepted sample steps through PROD, SQR, MLO, MHI, TERM and
//   ACC before the next one is accepted. The shared 33x33 multiplier is
//   used four times per sample (product, radius square, two halves of
//   weight * sample), then the term is formed and accumulated. After the
//   last point of a run the 64-bit divider produces one quotient bit per
//   cycle; the result word is issued after a rounding step, and the next run may start right after that.
// Reset (rst, synchronous): registers return to planar, solid, offset 0,
//   two points, no product; the point index and both sums clear and no
//   result word is pending.
// Stall: a pending result holds in the output register until taken; the next
//   run can be fed meanwhile, and a new result waits until the old one left.
`default_nettype none

module radial_weighted_grid_average (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [2*rwga_pkg::SMP_W-1:0]    s_tdata,   // sample_f, sample_g
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [rwga_pkg::SMP_W-1:0]      m_tdata,   // average
  output logic [0:0]                      m_tuser,   // saturated
  input  logic                            cfg_we,
  input  logic [rwga_pkg::CIDX_W-1:0]     cfg_index,
  input  logic [rwga_pkg::CFG_W-1:0]      cfg_data
);
  import rwga_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;
  logic sat_bit;

  // Configuration registers; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.geometry_mode <= GEO_PLANAR;
      cfg_q.is_shell      <= 1'b0;
      cfg_q.grid_offset   <= '0;
      cfg_q.num_points    <= NP_W'(2);
      cfg_q.use_product   <= 1'b0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_GEOMETRY: cfg_q.geometry_mode <= cfg_data[1:0];
        REG_SHELL:    cfg_q.is_shell      <= cfg_data[0];
        REG_OFFSET:   cfg_q.grid_offset   <= cfg_data[OFS_W-1:0];
        REG_POINTS:   cfg_q.num_points    <= cfg_data[NP_W-1:0];
        REG_PRODUCT:  cfg_q.use_product   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  rwga_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rwga_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_q),
    .cmd       (cmd),
    .sts       (sts),
    .sample_f  (s_tdata[SMP_W-1:0]),
    .sample_g  (s_tdata[2*SMP_W-1:SMP_W]),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .average   (m_tdata),
    .saturated (sat_bit)
  );

  assign m_tuser[0] = sat_bit;

endmodule

`default_nettype wire

@@ rtl/rwga_ctrl.sv @@
`default_nettype none

module rwga_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  rwga_pkg::sts_t  sts,
  output rwga_pkg::cmd_t  cmd
);
  import rwga_pkg::*;

  state_t              state, state_next;
  logic [DCNT_W-1:0]   dcnt, dcnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      dcnt  <= '0;
    end else begin
      state <= state_next;
      dcnt  <= dcnt_next;
    end
  end

  always_comb begin
    state_next = state;
    dcnt_next  = dcnt;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_PROD;
        end
      end
      ST_PROD: begin
        cmd.prod   = 1'b1;
        state_next = ST_SQR;
      end
      ST_SQR: begin
        cmd.sqr    = 1'b1;
        state_next = ST_MLO;
      end
      ST_MLO: begin
        cmd.mlo    = 1'b1;
        state_next = ST_MHI;
      end
      ST_MHI: begin
        cmd.mhi    = 1'b1;
        state_next = ST_TERM;
      end
      ST_TERM: begin
        cmd.term   = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc    = 1'b1;
        state_next = sts.last ? ST_DINIT : ST_IDLE;
      end
      ST_DINIT: begin
        cmd.dinit  = 1'b1;
        dcnt_next  = '0;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.dstep = 1'b1;
        dcnt_next = dcnt + 1'b1;
        if (dcnt == DCNT_W'(DIV_STEPS - 1)) begin
          state_next = ST_RND;
        end
      end
      ST_RND: begin
        cmd.rnd    = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!sts.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/rwga_dp.sv @@
`default_nettype none

module rwga_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  rwga_pkg::cfg_t               cfg,
  input  rwga_pkg::cmd_t               cmd,
  output rwga_pkg::sts_t               sts,
  input  logic [rwga_pkg::SMP_W-1:0]   sample_f,
  input  logic [rwga_pkg::SMP_W-1:0]   sample_g,
  input  logic                         m_tready,
  output logic                         m_tvalid,
  output logic [rwga_pkg::SMP_W-1:0]   average,
  output logic                         saturated
);
  import rwga_pkg::*;

  // Run state
  logic [IDX_W-1:0]  idx_q;
  logic [ACC_W-1:0]  wsum_q;
  logic [ACC_W-1:0]  wt_q;
  logic              flag_q;

  // Per-word payload
  logic [SMP_W-1:0]  f_q, g_q, s_q, m_q;
  logic              neg_q;
  logic [X_W-1:0]    x_q;
  logic [WGT_W-1:0]  w_q;
  logic [ACC_W-1:0]  plo_q;
  logic [WHI_W+LO_W-1:0] phi_q;
  logic [ACC_W-1:0]  term_q;

  // Divider
  logic [ACC_W-1:0]  quo_q, rem_q;
  logic [ACC_W:0]    qr_q;
  logic              dneg_q;

  // Point count and index handling
  logic [CMP_W-1:0]  np_w, n_eff, n_m1, idx_ext;
  logic [IDX_W-1:0]  idx_clamp;
  logic              first, last, half;

  assign np_w    = CMP_W'(cfg.num_points);
  assign idx_ext = CMP_W'(idx_q);
  assign n_m1    = n_eff - CMP_W'(1);

  always_comb begin
    if (np_w < CMP_W'(2)) begin
      n_eff = CMP_W'(2);
    end else if (np_w > CMP_W'(MAX_POINTS)) begin
      n_eff = CMP_W'(MAX_POINTS);
    end else begin
      n_eff = np_w;
    end
  end

  assign idx_clamp = (idx_ext >= n_eff) ? n_m1[IDX_W-1:0] : idx_q;
  assign first     = (idx_q == '0);
  assign last      = !first && ((idx_ext + CMP_W'(1)) >= n_eff);
  assign half      = first | last;

  assign sts.last     = last;
  assign sts.out_busy = m_tvalid & ~m_tready;

  // Shared multiplier: product, radius square, two halves of weight * |sample|
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_p;

  always_comb begin
    if (cmd.prod) begin
      mul_a = $signed({f_q[SMP_W-1], f_q});
      mul_b = $signed({g_q[SMP_W-1], g_q});
    end else if (cmd.sqr) begin
      mul_a = $signed(MUL_W'(x_q));
      mul_b = $signed(MUL_W'(x_q));
    end else if (cmd.mlo) begin
      mul_a = $signed(MUL_W'(w_q[LO_W-1:0]));
      mul_b = $signed(MUL_W'(m_q));
    end else begin
      mul_a = $signed(MUL_W'(w_q[WGT_W-1:LO_W]));
      mul_b = $signed(MUL_W'(m_q));
    end
  end

  assign mul_p = mul_a * mul_b;

  // Product rounded to Q16.16: add half an LSB, floor, saturate
  logic [2*SMP_W:0]  rnd_p;
  logic              prod_ok;
  logic [SMP_W-1:0]  prod_val;

  assign rnd_p    = {mul_p[2*SMP_W-1], mul_p[2*SMP_W-1:0]} + ((2*SMP_W+1)'(1) << 15);
  assign prod_ok  = (&rnd_p[2*SMP_W:SMP_W+15]) | ~(|rnd_p[2*SMP_W:SMP_W+15]);
  assign prod_val = prod_ok ? rnd_p[SMP_W+15:16] : (rnd_p[2*SMP_W] ? SMP_MIN : SMP_MAX);

  // Radius of the current point
  logic [X_W-1:0] x0, x_sum;
  assign x0    = cfg.is_shell ? X_W'(cfg.grid_offset) : '0;
  assign x_sum = x0 + (X_W'(idx_q) << 8);

  // Trapezoid weight
  logic [WGT_W-1:0] sq, sq_half, w_next;
  logic [WGT_W:0]   sq_inc;
  logic             is_cyl, is_sph;

  assign is_cyl  = (cfg.geometry_mode == GEO_CYL);
  assign is_sph  = (cfg.geometry_mode == GEO_SPH);
  assign sq      = mul_p[WGT_W-1:0];
  assign sq_inc  = {1'b0, sq} + (WGT_W+1)'(1);
  assign sq_half = sq_inc[WGT_W:1];

  always_comb begin
    if (!is_cyl && !is_sph) begin
      w_next = half ? W_HALF : W_FULL;
    end else if (first && !cfg.is_shell) begin
      w_next = is_cyl ? W_CYL_CTR : W_SPH_CTR;
    end else if (is_cyl) begin
      w_next = half ? (WGT_W'(x_q) << 7) : (WGT_W'(x_q) << 8);
    end else begin
      w_next = half ? sq_half : sq;
    end
  end

  // Signed term, saturated to +-(2^63-1)
  logic [TERM_W-1:0] full;
  logic              tsat;
  logic [ACC_W-1:0]  mag;

  assign full = TERM_W'({phi_q, {LO_W{1'b0}}}) + TERM_W'(plo_q);
  assign tsat = |full[TERM_W-1:ACC_W-1];
  assign mag  = tsat ? ACC_MAX : full[ACC_W-1:0];

  // Saturating accumulators
  logic [ACC_W:0]   wsum_add, wt_add;
  logic             wsum_of;
  logic [ACC_W-1:0] wsum_next, wt_next;

  assign wsum_add  = {wsum_q[ACC_W-1], wsum_q} + {term_q[ACC_W-1], term_q};
  assign wsum_of   = wsum_add[ACC_W] ^ wsum_add[ACC_W-1];
  assign wsum_next = wsum_of ? (wsum_add[ACC_W] ? ACC_MIN : ACC_MAX) : wsum_add[ACC_W-1:0];
  assign wt_add    = {1'b0, wt_q} + (ACC_W+1)'(w_q);
  assign wt_next   = wt_add[ACC_W] ? {ACC_W{1'b1}} : wt_add[ACC_W-1:0];

  // Restoring divider, one quotient bit per step
  logic [ACC_W:0]   rem_sh, rem_sub;
  logic             ge, round_up;

  assign rem_sh   = {rem_q, quo_q[ACC_W-1]};
  assign rem_sub  = rem_sh - {1'b0, wt_q};
  assign ge       = (rem_sh >= {1'b0, wt_q});
  assign round_up = ({rem_q, 1'b0} >= {1'b0, wt_q});

  // Final saturation and sign
  logic             avg_sat, div_zero;
  logic [SMP_W-1:0] qs, avg_val;

  assign div_zero = (wt_q == '0);
  assign avg_sat  = !div_zero && (dneg_q ? (qr_q > (ACC_W+1)'(SMP_MIN))
                                         : (qr_q > (ACC_W+1)'(SMP_MAX)));
  assign qs       = avg_sat ? (dneg_q ? SMP_MIN : SMP_MAX) : qr_q[SMP_W-1:0];
  assign avg_val  = div_zero ? '0 : (dneg_q ? (~qs + 1'b1) : qs);

  // Control-side state
  always_ff @(posedge clk) begin
    if (rst) begin
      idx_q    <= '0;
      wsum_q   <= '0;
      wt_q     <= '0;
      flag_q   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (cmd.load) begin
        idx_q <= idx_clamp;
      end else if (cmd.prod) begin
        flag_q <= flag_q | (cfg.use_product & ~prod_ok);
      end else if (cmd.term) begin
        flag_q <= flag_q | tsat;
      end else if (cmd.acc) begin
        wsum_q <= wsum_next;
        wt_q   <= wt_next;
        flag_q <= flag_q | wsum_of | wt_add[ACC_W];
        if (!last) begin
          idx_q <= idx_q + 1'b1;
        end
      end else if (cmd.emit) begin
        // clear the run
        idx_q  <= '0;
        wsum_q <= '0;
        wt_q   <= '0;
        flag_q <= 1'b0;
      end
    end
  end

  // Datapath payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      f_q <= sample_f;
      g_q <= sample_g;
    end
    if (cmd.prod) begin
      s_q <= cfg.use_product ? prod_val : f_q;
      x_q <= x_sum;
    end
    if (cmd.sqr) begin
      w_q   <= w_next;
      m_q   <= s_q[SMP_W-1] ? (~s_q + 1'b1) : s_q;
      neg_q <= s_q[SMP_W-1];
    end
    if (cmd.mlo) begin
      plo_q <= mul_p[ACC_W-1:0];
    end
    if (cmd.mhi) begin
      phi_q <= mul_p[WHI_W+LO_W-1:0];
    end
    if (cmd.term) begin
      term_q <= neg_q ? (~mag + 1'b1) : mag;
    end
    if (cmd.dinit) begin
      dneg_q <= wsum_q[ACC_W-1];
      quo_q  <= wsum_q[ACC_W-1] ? (~wsum_q + 1'b1) : wsum_q;
      rem_q  <= '0;
    end
    if (cmd.dstep) begin
      rem_q <= ge ? rem_sub[ACC_W-1:0] : rem_sh[ACC_W-1:0];
      quo_q <= {quo_q[ACC_W-2:0], ge};
    end
    if (cmd.rnd) begin
      qr_q <= {1'b0, quo_q} + (ACC_W+1)'(round_up);
    end
    if (cmd.emit) begin
      average   <= avg_val;
      saturated <= flag_q | avg_sat;
    end
  end

endmodule

`default_nettype wire

@@ rtl/rwga_chk.sv @@
`default_nettype none

module rwga_chk (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [rwga_pkg::SMP_W-1:0]  m_tdata,
  input logic [0:0]                  m_tuser
);
  import rwga_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // one sample in flight at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted on back-to-back cycles");

  // a result is launched only from the busy sequence
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared while input side was idle");

  // no result right behind an accept
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !$rose(m_tvalid))
    else $error("result appeared one cycle after an accept");

  // reset drops any pending result
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind radial_weighted_grid_average rwga_chk u_rwga_chk (.*);

`default_nettype wire

@@ tb/tb_radial_weighted_grid_average.sv @@
`default_nettype none

module tb_radial_weighted_grid_average;
  import rwga_pkg::*;

  // Mode three has no name in the package; the block treats it as planar.
  localparam logic [1:0] GEO_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 80;    // room for the division after the last word
  localparam int HOLD_CYCLES   = 1500;  // long receiver hold-off, fills the block up
  localparam int MAX_REPORTS   = 10;

  logic                    clk;
  logic                    rst;
  logic                    s_tvalid;
  logic                    s_tready;
  logic [2*SMP_W-1:0]      s_tdata;   // sample_f, sample_g
  logic                    m_tvalid;
  logic                    m_tready;
  logic [SMP_W-1:0]        m_tdata;   // average
  logic [0:0]              m_tuser;   // saturated
  logic                    cfg_we;
  logic [CIDX_W-1:0]       cfg_index;
  logic [CFG_W-1:0]        cfg_data;

  radial_weighted_grid_average uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // One expected output word: the run average and its saturation flag.
  typedef struct {
    logic [SMP_W-1:0] avg;
    bit               sat;
  } run_result_t;

  run_result_t pending_averages[$];

  // Local copy of the register file.
  logic [1:0]       geo_mode;
  logic             shell_mode;
  logic [OFS_W-1:0] inner_offset;
  logic [NP_W-1:0]  point_count;
  logic             product_mode;

  // Local copy of the run state.
  int unsigned      grid_index;
  logic [63:0]      weighted_acc;   // signed, units of 2^-32
  logic [63:0]      weight_acc;     // unsigned Q.16
  bit               sat_seen;

  int  mismatch_count;
  int  snd_idle_pct;
  int  rcv_stall_pct;
  bit  hold_req;
  bit  rx_hold;

  // Directed stimulus table: register writes and sample words, some with a
  // result typed in by hand.
  typedef enum {ROW_WRITE, ROW_WORD} row_kind_t;
  typedef struct {
    row_kind_t        kind;
    reg_idx_t         idx;
    logic [SMP_W-1:0] f;
    logic [SMP_W-1:0] g;
    bit               typed;
    logic [SMP_W-1:0] avg;
    bit               sat;
  } stim_row_t;

  stim_row_t directed_rows[$];

  function automatic void add_write(reg_idx_t idx, logic [CFG_W-1:0] val);
    directed_rows.push_back('{ROW_WRITE, idx, SMP_W'(val), '0, 1'b0, '0, 1'b0});
  endfunction

  function automatic void add_word(logic [SMP_W-1:0] f, logic [SMP_W-1:0] g);
    directed_rows.push_back('{ROW_WORD, REG_GEOMETRY, f, g, 1'b0, '0, 1'b0});
  endfunction

  function automatic void add_checked_word(logic [SMP_W-1:0] f, logic [SMP_W-1:0] g,
                                           logic [SMP_W-1:0] avg, bit sat);
    directed_rows.push_back('{ROW_WORD, REG_GEOMETRY, f, g, 1'b1, avg, sat});
  endfunction

  // Effective run length: clamp the register to [2, MAX_POINTS].
  function automatic int unsigned run_length();
    int unsigned n;
    n = 32'(point_count);
    if (n < 2) n = 2;
    if (n > MAX_POINTS) n = MAX_POINTS;
    return n;
  endfunction

  // Trapezoid weight of grid point i in a run of n points, unsigned Q.16.
  function automatic logic [63:0] trapezoid_weight(int unsigned i, int unsigned n);
    bit          first;
    bit          edge_pt;
    logic [1:0]  geo;
    logic [63:0] x;
    first   = (i == 0);
    edge_pt = first || (i + 1 >= n);
    geo     = (geo_mode == GEO_CYL || geo_mode == GEO_SPH) ? geo_mode : GEO_PLANAR;
    if (geo == GEO_PLANAR)
      return edge_pt ? 64'(W_HALF) : 64'(W_FULL);
    // solid body: the center point takes a fixed fraction
    if (first && !shell_mode)
      return (geo == GEO_CYL) ? 64'(W_CYL_CTR) : 64'(W_SPH_CTR);
    x = (shell_mode ? 64'(inner_offset) : 64'd0) + (64'(i) << 8);
    if (geo == GEO_CYL)
      return edge_pt ? (x << 7) : (x << 8);
    return edge_pt ? ((x * x + 64'd1) >> 1) : (x * x);
  endfunction

  // Fold one grid point into the run. Returns 1 when the run closes, with the
  // rounded average and the saturation flag.
  function automatic bit accumulate_point(logic [SMP_W-1:0] f, logic [SMP_W-1:0] g,
                                          output logic [SMP_W-1:0] avg,
                                          output bit sat);
    int unsigned      n;
    longint           s;
    longint           p;
    logic [63:0]      w;
    logic [63:0]      mag;
    logic [127:0]     full;
    logic [63:0]      term;
    logic [64:0]      acc;
    logic [64:0]      wacc;
    logic [63:0]      q;
    logic [63:0]      r;
    bit               neg;
    avg = '0;
    sat = 1'b0;
    n = run_length();
    if (grid_index + 1 > n) grid_index = n - 1;

    s = longint'($signed(f));
    if (product_mode) begin
      // round the Q32.32 product to Q16.16: add half an LSB, floor
      p = (s * longint'($signed(g)) + 64'sd32768) >>> 16;
      if (p > 64'sh7FFF_FFFF) begin
        sat_seen = 1'b1;
        p = 64'sh7FFF_FFFF;
      end else if (p < -64'sh8000_0000) begin
        sat_seen = 1'b1;
        p = -64'sh8000_0000;
      end
      s = p;
    end

    w    = trapezoid_weight(grid_index, n);
    neg  = (s < 0);
    mag  = neg ? 64'(-s) : 64'(s);
    full = 128'(w) * 128'(mag);
    if (full > 128'h7FFF_FFFF_FFFF_FFFF) begin
      sat_seen = 1'b1;
      full = 128'h7FFF_FFFF_FFFF_FFFF;
    end
    term = neg ? -full[63:0] : full[63:0];

    // signed 64-bit add with clamp on overflow
    acc = {weighted_acc[63], weighted_acc} + {term[63], term};
    if (acc[64] != acc[63]) begin
      sat_seen = 1'b1;
      weighted_acc = acc[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      weighted_acc = acc[63:0];
    end
    wacc = {1'b0, weight_acc} + {1'b0, w};
    if (wacc[64]) begin
      sat_seen = 1'b1;
      weight_acc = '1;
    end else begin
      weight_acc = wacc[63:0];
    end

    if (grid_index + 1 < n) begin
      grid_index++;
      return 1'b0;
    end

    // divide, round to nearest with ties away from zero, clamp
    if (weight_acc != 0) begin
      neg = weighted_acc[63];
      mag = neg ? -weighted_acc : weighted_acc;
      q   = mag / weight_acc;
      r   = mag % weight_acc;
      if (r >= weight_acc - r) q++;
      if (!neg && q > 64'h7FFF_FFFF) begin
        sat_seen = 1'b1;
        q = 64'h7FFF_FFFF;
      end
      if (neg && q > 64'h8000_0000) begin
        sat_seen = 1'b1;
        q = 64'h8000_0000;
      end
      avg = neg ? -q[31:0] : q[31:0];
    end
    sat = sat_seen;
    grid_index   = 0;
    weighted_acc = '0;
    weight_acc   = '0;
    sat_seen     = 1'b0;
    return 1'b1;
  endfunction

  // Random sample: extremes, zero, small values and full-range noise.
  function automatic logic [SMP_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return SMP_MAX;
      1:       return SMP_MIN;
      2:       return '0;
      3, 4, 5: return SMP_W'($signed($urandom_range(1 << 20)) - (1 << 19));
      default: return $urandom();
    endcase
  endfunction

  // Write one register; hold the enable for one edge, then drop it before returning.
  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_GEOMETRY: geo_mode     = val[1:0];
      REG_SHELL:    shell_mode   = val[0];
      REG_OFFSET:   inner_offset = val[OFS_W-1:0];
      REG_POINTS:   point_count  = val[NP_W-1:0];
      REG_PRODUCT:  product_mode = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Drop valid, wait for every expected word, then let the divider drain.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_averages.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Offer one sample word, maybe after an idle gap. Called and returns at a
  // rising edge; valid stays high for a following word without a gap.
  task automatic send_word(logic [SMP_W-1:0] f, logic [SMP_W-1:0] g,
                           bit typed, logic [SMP_W-1:0] t_avg, bit t_sat);
    logic [SMP_W-1:0] avg;
    bit               sat;
    if (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {g, f};
    // sample ready mid-cycle; the handshake lands on the next rising edge
    forever begin
      @(negedge clk);
      if (s_tready) break;
      @(posedge clk);
    end
    if (accumulate_point(f, g, avg, sat)) begin
      if (typed) pending_averages.push_back('{t_avg, t_sat});
      else       pending_averages.push_back('{avg, sat});
    end
    @(posedge clk);
  endtask

  // Receiver: random stalls, plus the long hold-off when asked.
  initial begin
    forever begin
      @(posedge clk);
      m_tready <= !rx_hold && ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // Long hold-off, counted here so the sender keeps pushing meanwhile.
  initial begin
    wait (hold_req);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Check each output word against the oldest expectation.
  always @(negedge clk) begin
    run_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_averages.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected word: average %h saturated %0d", m_tdata, m_tuser[0]);
      end else begin
        exp_r = pending_averages.pop_front();
        if (m_tdata !== exp_r.avg || m_tuser[0] !== exp_r.sat) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: average %h (exp %h) saturated %0d (exp %0d)",
                     m_tdata, exp_r.avg, m_tuser[0], exp_r.sat);
        end
      end
    end
  end

  // Hard stop, well past the slowest legal run.
  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    bit          in_run;
    int unsigned n;
    int unsigned runs;
    clk       = 1'b0;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    m_tready  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = REG_GEOMETRY;
    cfg_data  = '0;
    hold_req  = 1'b0;
    rx_hold   = 1'b0;
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    mismatch_count = 0;
    in_run = 1'b0;

    // reset values of the block
    geo_mode     = GEO_PLANAR;
    shell_mode   = 1'b0;
    inner_offset = '0;
    point_count  = NP_W'(2);
    product_mode = 1'b0;
    grid_index   = 0;
    weighted_acc = '0;
    weight_acc   = '0;
    sat_seen     = 1'b0;

    // Planar two-point runs after reset: 1.0 and 3.0 average to 2.0.
    add_word(32'h0001_0000, 32'hFFFF_FFFF);
    add_checked_word(32'h0003_0000, 32'h0000_0000, 32'h0002_0000, 1'b0);
    // full-scale samples average back to themselves without saturating
    add_word(SMP_MAX, 32'h0000_0000);
    add_checked_word(SMP_MAX, 32'hFFFF_FFFF, SMP_MAX, 1'b0);
    add_word(SMP_MIN, 32'h5555_5555);
    add_checked_word(SMP_MIN, 32'hAAAA_AAAA, SMP_MIN, 1'b0);
    // product overflows clamp both ways and raise the flag
    add_write(REG_PRODUCT, 24'd1);
    add_word(SMP_MIN, SMP_MIN);
    add_checked_word(SMP_MIN, SMP_MIN, SMP_MAX, 1'b1);
    add_word(SMP_MAX, SMP_MIN);
    add_checked_word(SMP_MAX, SMP_MIN, SMP_MIN, 1'b1);
    // mode three behaves as planar
    add_write(REG_PRODUCT, 24'd0);
    add_write(REG_GEOMETRY, CFG_W'(GEO_SPARE));
    add_write(REG_POINTS, 24'd3);
    add_word(32'h0002_0000, 32'h1234_5678);
    add_word(32'hFFFE_8000, 32'h0000_0000);
    add_word(32'h0005_0000, 32'h0000_0000);
    // planar ignores shell and offset; a count below two means two
    add_write(REG_GEOMETRY, CFG_W'(GEO_PLANAR));
    add_write(REG_SHELL, 24'd1);
    add_write(REG_OFFSET, 24'hFF_FFFF);
    add_write(REG_POINTS, 24'd0);
    add_word(32'h0001_8000, 32'h0000_0000);
    add_word(32'hFFFF_0000, 32'h0000_0000);
    // solid cylinder with a stale offset: center weight, offset dropped
    add_write(REG_GEOMETRY, CFG_W'(GEO_CYL));
    add_write(REG_SHELL, 24'd0);
    add_write(REG_POINTS, 24'd1);
    add_word(32'h0004_0000, 32'h0000_0000);
    add_word(32'h0000_4000, 32'h0000_0000);
    // spherical shell at the largest offset, product on
    add_write(REG_GEOMETRY, CFG_W'(GEO_SPH));
    add_write(REG_SHELL, 24'd1);
    add_write(REG_POINTS, 24'd4);
    add_write(REG_PRODUCT, 24'd1);
    add_word(32'h0002_0000, 32'h0003_0000);
    add_word(32'hFFFF_8000, 32'h0001_0000);
    add_word(32'h7FFF_0000, 32'h0002_0000);
    add_word(32'h0000_0001, 32'h0000_0001);
    // solid sphere: center weight of one twenty-fourth
    add_write(REG_SHELL, 24'd0);
    add_write(REG_OFFSET, 24'd0);
    add_write(REG_POINTS, 24'd3);
    add_word(32'h0010_0000, 32'h0001_0000);
    add_word(32'h0001_0000, 32'hFFFF_0000);
    add_word(32'h0003_0000, 32'h0002_0000);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part: walk the table; settle before any write after words.
    foreach (directed_rows[k]) begin
      if (directed_rows[k].kind == ROW_WRITE) begin
        if (in_run) settle();
        in_run = 1'b0;
        write_reg(directed_rows[k].idx, directed_rows[k].f[CFG_W-1:0]);
      end else begin
        send_word(directed_rows[k].f, directed_rows[k].g, directed_rows[k].typed,
                  directed_rows[k].avg, directed_rows[k].sat);
        in_run = 1'b1;
      end
    end

    // Random part: 32 segments in four idling phases, each with a fresh
    // register setting and about 16 words of whole runs.
    for (int seg = 0; seg < 32; seg++) begin
      settle();
      case (seg / 8)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 74; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 74; end
        default: begin snd_idle_pct = 34; rcv_stall_pct = 34; end
      endcase
      write_reg(REG_GEOMETRY, CFG_W'($urandom_range(3)));
      write_reg(REG_SHELL, CFG_W'($urandom_range(1)));
      case ($urandom_range(3))
        0: write_reg(REG_OFFSET, 24'd0);
        1: write_reg(REG_OFFSET, 24'hFF_FFFF);
        2: write_reg(REG_OFFSET, CFG_W'($urandom_range(4095)));
        default: write_reg(REG_OFFSET, CFG_W'($urandom()));
      endcase
      case ($urandom_range(7))
        0: write_reg(REG_POINTS, 24'd0);
        1: write_reg(REG_POINTS, 24'd1);
        2: write_reg(REG_POINTS, 24'd2);
        default: write_reg(REG_POINTS, CFG_W'($urandom_range(12, 3)));
      endcase
      write_reg(REG_PRODUCT, CFG_W'($urandom_range(1)));
      n    = run_length();
      runs = (n >= 16) ? 1 : 16 / n;
      // once: hold the receiver off so results back up and stall the input
      if (seg == 4) begin
        hold_req <= 1'b1;
        if (runs < 3) runs = 3;
      end
      repeat (runs)
        repeat (n) send_word(pick_sample(), pick_sample(), 1'b0, '0, 1'b0);
    end

    // A count above the limit clamps to it; shrinking the count mid-run
    // closes the run at the next word.
    settle();
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    write_reg(REG_GEOMETRY, CFG_W'($urandom_range(3)));
    write_reg(REG_SHELL, CFG_W'($urandom_range(1)));
    write_reg(REG_OFFSET, CFG_W'($urandom()));
    write_reg(REG_POINTS, CFG_W'(8191));
    write_reg(REG_PRODUCT, CFG_W'($urandom_range(1)));
    repeat (6) send_word(pick_sample(), pick_sample(), 1'b0, '0, 1'b0);
    settle();
    write_reg(REG_POINTS, 24'd3);
    send_word(pick_sample(), pick_sample(), 1'b0, '0, 1'b0);

    settle();
    if (mismatch_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire
